/* sv/lottery_ticket_scheduler_defines.svh */
// Assertion macros shared by the lottery ticket scheduler RTL
`ifndef LOTTERY_TICKET_SCHEDULER_DEFINES_SVH
`define LOTTERY_TICKET_SCHEDULER_DEFINES_SVH
`ifndef SYNTHESIS
`define LTS_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define LTS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LTS_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg)
`define LTS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif
`endif

/* sv/ltsch_pkg.sv */
// Shared constants, codes and control types of the lottery ticket scheduler
package ltsch_pkg;

    localparam int MAX_REQUESTERS_DEF = 16;
    localparam int TICKETS_FULL_DEF   = 100;
    localparam int TABLE_DEPTH_DEF    = 2048;
    localparam int RANDOM_BITS_DEF    = 15;

    localparam int FUNC_W     = 2;
    localparam int NUM_OPS_W  = 5;
    localparam int CYCLE_W    = 16;
    localparam int TUPLES_W   = 16;
    localparam int SUM_W      = 17;
    localparam int GRANT_W    = 4;
    localparam int LENGTH_W   = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [FUNC_W-1:0] FUNC_START  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DRAW   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REPORT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_OPS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REFRESH_LEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALT_MODE    = 2'd2;

    localparam logic [NUM_OPS_W-1:0] NUM_OPS_RST     = 5'd1;
    localparam logic [CYCLE_W-1:0]   REFRESH_LEN_RST = 16'd50;
    localparam logic [SUM_W-1:0]     SUM_MAX         = 17'h1FFFF;

    typedef struct packed {
        logic load_item;
        logic start_init;
        logic accum;
        logic refresh_init;
        logic prep;
        logic fill;
        logic commit;
        logic rd;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              count_zero;
        logic              sum_reached;
        logic              n_zero;
        logic              last_ticket;
    } dp_stat_t;

    function automatic int op_width(input int max_req);
        return (max_req > 1) ? $clog2(max_req) : 1;
    endfunction

endpackage

/* sv/ltsch_chan_if.sv */
// Valid/ready channel interfaces: item beats, result beats and register writes
interface ltsch_cmd_if #(
    parameter int RANDOM_BITS = ltsch_pkg::RANDOM_BITS_DEF
) ();
    import ltsch_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [FUNC_W-1:0]      func;
    logic [RANDOM_BITS-1:0] random_value;
    logic [TUPLES_W-1:0]    tuples_done;

    modport source (output valid, output func, output random_value, output tuples_done,
                    input ready);
    modport sink (input valid, input func, input random_value, input tuples_done,
                  output ready);
endinterface

interface ltsch_rsp_if ();
    import ltsch_pkg::*;

    logic                valid;
    logic                ready;
    logic [GRANT_W-1:0]  granted_op;
    logic                grant_valid;
    logic                refreshed;
    logic [LENGTH_W-1:0] table_length;

    modport source (output valid, output granted_op, output grant_valid, output refreshed,
                    output table_length, input ready);
    modport sink (input valid, input granted_op, input grant_valid, input refreshed,
                  input table_length, output ready);
endinterface

interface ltsch_cfg_if ();
    import ltsch_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* sv/ltsch_ram.sv */
// Generic single-write, single-read RAM with registered read data
module ltsch_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = ltsch_pkg::TABLE_DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

/* sv/ltsch_dp.sv */
// Datapath: registers, tuple sum, ticket table sweep counters, draw scaling, result register
module ltsch_dp #(
    parameter int MAX_REQUESTERS = ltsch_pkg::MAX_REQUESTERS_DEF,
    parameter int TICKETS_FULL   = ltsch_pkg::TICKETS_FULL_DEF,
    parameter int TABLE_DEPTH    = ltsch_pkg::TABLE_DEPTH_DEF,
    parameter int RANDOM_BITS    = ltsch_pkg::RANDOM_BITS_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        cfg_we,
    input  logic [ltsch_pkg::CFG_IDX_W-1:0]             cfg_index,
    input  logic [ltsch_pkg::CFG_DATA_W-1:0]            cfg_data,
    input  logic [ltsch_pkg::FUNC_W-1:0]                item_func,
    input  logic [RANDOM_BITS-1:0]                      item_random,
    input  logic [ltsch_pkg::TUPLES_W-1:0]              item_tuples,
    input  ltsch_pkg::dp_cmd_t                          cmd,
    output ltsch_pkg::dp_stat_t                         stat,
    output logic                                        ram_we,
    output logic [$clog2(TABLE_DEPTH)-1:0]              ram_waddr,
    output logic [ltsch_pkg::op_width(MAX_REQUESTERS)-1:0] ram_wdata,
    output logic                                        ram_re,
    output logic [$clog2(TABLE_DEPTH)-1:0]              ram_raddr,
    input  logic [ltsch_pkg::op_width(MAX_REQUESTERS)-1:0] ram_rdata,
    output logic [ltsch_pkg::GRANT_W-1:0]               granted_op,
    output logic                                        grant_valid,
    output logic                                        refreshed,
    output logic [ltsch_pkg::LENGTH_W-1:0]              table_length
);
    import ltsch_pkg::*;

    localparam int NW     = $clog2(MAX_REQUESTERS + 1);
    localparam int OP_W   = op_width(MAX_REQUESTERS);
    localparam int AW     = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int TW     = $clog2(TICKETS_FULL);
    localparam int PROD_W = CNT_W + RANDOM_BITS;

    localparam logic [TW-1:0]    LAST_FULL = TW'(TICKETS_FULL - 1);
    localparam logic [TW-1:0]    LAST_HALF = TW'(TICKETS_FULL / 2 - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);
    localparam logic [NW-1:0]    N_MAX     = NW'(MAX_REQUESTERS);

    logic [NUM_OPS_W-1:0]   num_ops_reg, num_ops_next;
    logic [CYCLE_W-1:0]     cycle_len_reg, cycle_len_next;
    logic                   alt_mode_reg, alt_mode_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic                   parity_reg, parity_next;
    logic                   op0_high_reg, op0_high_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   swapped_reg, swapped_next;
    logic                   start_mode_reg, start_mode_next;
    logic                   maxp_high_reg, maxp_high_next;
    logic [NW-1:0]          n_reg, n_next;
    logic [NW-1:0]          op_reg, op_next;
    logic [TW-1:0]          tick_reg, tick_next;
    logic [CNT_W-1:0]       build_reg, build_next;
    logic                   grant_flag_reg, grant_flag_next;
    logic                   refreshed_flag_reg, refreshed_flag_next;

    logic [FUNC_W-1:0]      func_reg;
    logic [RANDOM_BITS-1:0] rnd_reg;
    logic [TUPLES_W-1:0]    tuples_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [GRANT_W-1:0]     granted_op_reg;
    logic                   grant_valid_reg;
    logic                   refreshed_reg;
    logic [LENGTH_W-1:0]    length_reg;

    logic [31:0]            nops_wide;
    logic [NW-1:0]          n_clamp;
    logic                   any_high;
    logic                   op_high;
    logic [TW-1:0]          tick_last;
    logic                   room;
    logic [SUM_W:0]         sum_wide;
    logic [SUM_W-1:0]       sum_sat;
    logic [CNT_W-1:0]       draw_idx;

    assign nops_wide = 32'(num_ops_reg);
    assign n_clamp   = (nops_wide > 32'(MAX_REQUESTERS)) ? N_MAX : NW'(nops_wide);
    assign any_high  = (n_clamp != '0)
                       && (swapped_reg || ((n_clamp - 1'b1) > (n_clamp >> 1)));
    assign op_high   = (op_reg > (n_reg >> 1)) ^ swapped_reg;
    assign tick_last = (op_high == maxp_high_reg) ? LAST_FULL : LAST_HALF;
    assign room      = build_reg < DEPTH_CNT;
    assign sum_wide  = {1'b0, sum_reg} + (SUM_W + 1)'(tuples_reg);
    assign sum_sat   = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
    assign draw_idx  = prod_reg[PROD_W-1:RANDOM_BITS];

    assign stat.func        = func_reg;
    assign stat.count_zero  = count_reg == '0;
    assign stat.sum_reached = sum_reg >= SUM_W'(cycle_len_reg);
    assign stat.n_zero      = n_clamp == '0;
    assign stat.last_ticket = (tick_reg == tick_last) && (op_reg == n_reg - 1'b1);

    assign ram_we    = cmd.fill && room;
    assign ram_waddr = build_reg[AW-1:0];
    assign ram_wdata = op_reg[OP_W-1:0];
    assign ram_re    = cmd.rd;
    assign ram_raddr = draw_idx[AW-1:0];

    always_comb
    begin
        num_ops_next   = num_ops_reg;
        cycle_len_next = cycle_len_reg;
        alt_mode_next  = alt_mode_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_NUM_OPS:     num_ops_next   = cfg_data[NUM_OPS_W-1:0];
                REG_REFRESH_LEN: cycle_len_next = cfg_data[CYCLE_W-1:0];
                REG_ALT_MODE:    alt_mode_next  = cfg_data[0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        sum_next            = sum_reg;
        parity_next         = parity_reg;
        op0_high_next       = op0_high_reg;
        count_next          = count_reg;
        swapped_next        = swapped_reg;
        start_mode_next     = start_mode_reg;
        maxp_high_next      = maxp_high_reg;
        n_next              = n_reg;
        op_next             = op_reg;
        tick_next           = tick_reg;
        build_next          = build_reg;
        grant_flag_next     = grant_flag_reg;
        refreshed_flag_next = refreshed_flag_reg;

        if (cmd.load_item)
        begin
            grant_flag_next     = 1'b0;
            refreshed_flag_next = 1'b0;
        end
        if (cmd.start_init)
        begin
            sum_next        = '0;
            parity_next     = 1'b0;
            swapped_next    = 1'b0;
            start_mode_next = 1'b1;
        end
        if (cmd.accum)
        begin
            sum_next = sum_sat;
        end
        if (cmd.refresh_init)
        begin
            sum_next        = '0;
            start_mode_next = 1'b0;
            if (alt_mode_reg)
            begin
                swapped_next = parity_reg;
                parity_next  = ~parity_reg;
            end
            else
            begin
                swapped_next = op0_high_reg;
            end
        end
        if (cmd.prep)
        begin
            n_next         = n_clamp;
            maxp_high_next = op0_high_reg || any_high;
            op_next        = '0;
            tick_next      = '0;
            build_next     = '0;
        end
        if (cmd.fill)
        begin
            if (room)
            begin
                build_next = build_reg + 1'b1;
            end
            if (tick_reg == tick_last)
            begin
                tick_next = '0;
                op_next   = op_reg + 1'b1;
            end
            else
            begin
                tick_next = tick_reg + 1'b1;
            end
        end
        if (cmd.commit)
        begin
            if (start_mode_reg || (build_reg > count_reg))
            begin
                count_next = build_reg;
            end
            if (n_reg != '0)
            begin
                op0_high_next = swapped_reg;
            end
            refreshed_flag_next = 1'b1;
        end
        if (cmd.rd)
        begin
            grant_flag_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_ops_reg        <= NUM_OPS_RST;
            cycle_len_reg      <= REFRESH_LEN_RST;
            alt_mode_reg       <= 1'b0;
            sum_reg            <= '0;
            parity_reg         <= 1'b0;
            op0_high_reg       <= 1'b0;
            count_reg          <= '0;
            swapped_reg        <= 1'b0;
            start_mode_reg     <= 1'b0;
            maxp_high_reg      <= 1'b0;
            n_reg              <= '0;
            op_reg             <= '0;
            tick_reg           <= '0;
            build_reg          <= '0;
            grant_flag_reg     <= 1'b0;
            refreshed_flag_reg <= 1'b0;
        end
        else
        begin
            num_ops_reg        <= num_ops_next;
            cycle_len_reg      <= cycle_len_next;
            alt_mode_reg       <= alt_mode_next;
            sum_reg            <= sum_next;
            parity_reg         <= parity_next;
            op0_high_reg       <= op0_high_next;
            count_reg          <= count_next;
            swapped_reg        <= swapped_next;
            start_mode_reg     <= start_mode_next;
            maxp_high_reg      <= maxp_high_next;
            n_reg              <= n_next;
            op_reg             <= op_next;
            tick_reg           <= tick_next;
            build_reg          <= build_next;
            grant_flag_reg     <= grant_flag_next;
            refreshed_flag_reg <= refreshed_flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            func_reg   <= item_func;
            rnd_reg    <= item_random;
            tuples_reg <= item_tuples;
        end
        if (cmd.start_init || cmd.accum || cmd.refresh_init)
        begin
            prod_reg <= prod_reg;
        end
        else if (stat.func == FUNC_DRAW)
        begin
            prod_reg <= PROD_W'(count_reg) * PROD_W'(rnd_reg);
        end
        if (cmd.out_load)
        begin
            granted_op_reg  <= grant_flag_reg ? GRANT_W'(ram_rdata) : '0;
            grant_valid_reg <= grant_flag_reg;
            refreshed_reg   <= refreshed_flag_reg;
            length_reg      <= LENGTH_W'(count_reg);
        end
    end

    assign granted_op   = granted_op_reg;
    assign grant_valid  = grant_valid_reg;
    assign refreshed    = refreshed_reg;
    assign table_length = length_reg;
endmodule

/* sv/ltsch_ctrl.sv */
// Controller: sequences decode, tuple check, table sweep, draw read and result hand-off
`include "lottery_ticket_scheduler_defines.svh"

module ltsch_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  ltsch_pkg::dp_stat_t stat,
    output ltsch_pkg::dp_cmd_t  cmd
);
    import ltsch_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_DECODE = 8'b0000_0010,
        ST_CHECK  = 8'b0000_0100,
        ST_PREP   = 8'b0000_1000,
        ST_FILL   = 8'b0001_0000,
        ST_COMMIT = 8'b0010_0000,
        ST_RD     = 8'b0100_0000,
        ST_DONE   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = state_reg == ST_IDLE;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                unique case (stat.func)
                    FUNC_START:
                    begin
                        cmd.start_init = 1'b1;
                        state_next     = ST_PREP;
                    end
                    FUNC_DRAW:
                    begin
                        state_next = stat.count_zero ? ST_DONE : ST_RD;
                    end
                    FUNC_REPORT:
                    begin
                        cmd.accum  = 1'b1;
                        state_next = ST_CHECK;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_CHECK:
            begin
                if (stat.sum_reached)
                begin
                    cmd.refresh_init = 1'b1;
                    state_next       = ST_PREP;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = stat.n_zero ? ST_COMMIT : ST_FILL;
            end
            ST_FILL:
            begin
                cmd.fill = 1'b1;
                if (stat.last_ticket)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = ST_DONE;
            end
            ST_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `LTS_ASSERT_NEXT(a_accept_starts_decode, clk, rst_n, in_valid && in_ready, state_reg == ST_DECODE, "accepted beat did not start decode")
    `LTS_ASSERT_NEXT(a_done_waits_for_sink, clk, rst_n, (state_reg == ST_DONE) && out_valid_reg && !out_ready, state_reg == ST_DONE, "result left done while sink stalled")
    `LTS_ASSERT_NEXT(a_load_shows_result, clk, rst_n, cmd.out_load, out_valid_reg && (state_reg == ST_IDLE), "loaded result not presented")
    `LTS_ASSERT_IMPLY(a_fill_needs_requesters, clk, rst_n, (state_reg == ST_FILL) && $past(state_reg == ST_PREP), !$past(stat.n_zero), "sweep started with no requesters")
endmodule

/* sv/lottery_ticket_scheduler.sv */
// Lottery ticket scheduler top level: channel hookup of controller, datapath and ticket RAM
//
//  channel | role | beat carries
//  cmd     | sink   | func, random_value, tuples_done
//  rsp     | source | granted_op, grant_valid, refreshed, table_length
//  cfg     | sink   | index, data (register write, always ready)
//
// One item at a time; cmd.ready is high only when the controller is idle.
// The table sweep goes through the tickets of the taking part requesters, one per cycle.
// A result waiting on rsp holds the next result in the controller's final state;
// the next item is still accepted while that result waits. The ticket RAM needs
// no clearing after reset.
module lottery_ticket_scheduler #(
    parameter int MAX_REQUESTERS = ltsch_pkg::MAX_REQUESTERS_DEF,
    parameter int TICKETS_FULL   = ltsch_pkg::TICKETS_FULL_DEF,
    parameter int TABLE_DEPTH    = ltsch_pkg::TABLE_DEPTH_DEF,
    parameter int RANDOM_BITS    = ltsch_pkg::RANDOM_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    ltsch_cmd_if.sink   cmd,
    ltsch_rsp_if.source rsp,
    ltsch_cfg_if.sink   cfg
);
    import ltsch_pkg::*;

    localparam int OP_W = op_width(MAX_REQUESTERS);
    localparam int AW   = $clog2(TABLE_DEPTH);

    dp_cmd_t         dp_cmd;
    dp_stat_t        dp_stat;
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [OP_W-1:0] ram_wdata;
    logic            ram_re;
    logic [AW-1:0]   ram_raddr;
    logic [OP_W-1:0] ram_rdata;

    assign cfg.ready = 1'b1;

    ltsch_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (cmd.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (dp_stat),
        .cmd       (dp_cmd)
    );

    ltsch_dp #(
        .MAX_REQUESTERS (MAX_REQUESTERS),
        .TICKETS_FULL   (TICKETS_FULL),
        .TABLE_DEPTH    (TABLE_DEPTH),
        .RANDOM_BITS    (RANDOM_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg.valid && cfg.ready),
        .cfg_index    (cfg.index),
        .cfg_data     (cfg.data),
        .item_func    (cmd.func),
        .item_random  (cmd.random_value),
        .item_tuples  (cmd.tuples_done),
        .cmd          (dp_cmd),
        .stat         (dp_stat),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .ram_re       (ram_re),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata),
        .granted_op   (rsp.granted_op),
        .grant_valid  (rsp.grant_valid),
        .refreshed    (rsp.refreshed),
        .table_length (rsp.table_length)
    );

    ltsch_ram #(
        .WIDTH (OP_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );
endmodule

/* test/testbench.sv */
// Self-checking testbench for the lottery ticket scheduler: ticket table prediction and grant checks
module testbench;
    import ltsch_pkg::*;

    localparam int          CYCLE_LIMIT  = 8_000_000;
    localparam int          PHASES       = 12;
    localparam int          PHASE_ITEMS  = 54;
    localparam int unsigned PRIO_LOW     = 1;
    localparam int unsigned PRIO_HIGH    = 2;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    class lottery_scoreboard;
        typedef struct {
            logic [GRANT_W-1:0]  op;
            logic                granted;
            logic                rebuilt;
            logic [LENGTH_W-1:0] length;
        } grant_result_t;

        bit [NUM_OPS_W-1:0] num_ops;
        bit [CYCLE_W-1:0]   refresh_len;
        bit                 alt_mode;
        bit [GRANT_W-1:0]   tickets [TABLE_DEPTH_DEF];
        int unsigned        ticket_total;
        int unsigned        tuple_sum;
        bit                 parity;
        bit                 op0_high;
        grant_result_t      expected_q [$];
        int                 errors;
        int                 items;
        int                 grants;
        int                 rebuilds;

        function new();
            num_ops      = NUM_OPS_RST;
            refresh_len  = REFRESH_LEN_RST;
            alt_mode     = 1'b0;
            ticket_total = 0;
            tuple_sum    = 0;
            parity       = 1'b0;
            op0_high     = 1'b0;
            errors       = 0;
            items        = 0;
            grants       = 0;
            rebuilds     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_NUM_OPS:     num_ops = val[NUM_OPS_W-1:0];
                REG_REFRESH_LEN: refresh_len = val[CYCLE_W-1:0];
                REG_ALT_MODE:    alt_mode = val[0];
                default: ;
            endcase
        endfunction

        function int unsigned group_prio(int unsigned o, int unsigned n, bit swapped);
            bit high;
            high = o > (n / 2);
            if (swapped)
                high = !high;
            return high ? PRIO_HIGH : PRIO_LOW;
        endfunction

        // rewrite the table from entry 0, return tickets written
        function int unsigned rebuild(bit swapped);
            int unsigned n;
            int unsigned maxp;
            int unsigned written;
            int unsigned share;
            n = (num_ops > MAX_REQUESTERS_DEF) ? MAX_REQUESTERS_DEF : num_ops;
            maxp = op0_high ? PRIO_HIGH : PRIO_LOW;
            written = 0;
            for (int unsigned o = 0; o < n; o++)
            begin
                if (group_prio(o, n, swapped) > maxp)
                    maxp = group_prio(o, n, swapped);
            end
            for (int unsigned o = 0; o < n; o++)
            begin
                share = (group_prio(o, n, swapped) == maxp) ? TICKETS_FULL_DEF
                                                            : TICKETS_FULL_DEF / 2;
                for (int unsigned c = 0; c < share; c++)
                begin
                    if (written < TABLE_DEPTH_DEF)
                    begin
                        tickets[written] = o[GRANT_W-1:0];
                        written++;
                    end
                end
            end
            if (n > 0)
                op0_high = (group_prio(0, n, swapped) == PRIO_HIGH);
            return written;
        endfunction

        function void note_item(logic [FUNC_W-1:0] f, logic [RANDOM_BITS_DEF-1:0] rv,
                                logic [TUPLES_W-1:0] td);
            grant_result_t     e;
            bit                swapped;
            int unsigned       built;
            longint unsigned   slot;
            e = '{op: '0, granted: 1'b0, rebuilt: 1'b0, length: '0};
            case (f)
                FUNC_START:
                begin
                    tuple_sum    = 0;
                    parity       = 1'b0;
                    ticket_total = rebuild(1'b0);
                    e.rebuilt    = 1'b1;
                end
                FUNC_DRAW:
                begin
                    if (ticket_total > 0)
                    begin
                        slot = (64'(ticket_total) * 64'(rv)) >> RANDOM_BITS_DEF;
                        if (slot < ticket_total && slot < TABLE_DEPTH_DEF)
                        begin
                            e.op      = tickets[slot];
                            e.granted = 1'b1;
                        end
                    end
                end
                FUNC_REPORT:
                begin
                    tuple_sum += td;
                    if (tuple_sum > SUM_MAX)
                        tuple_sum = SUM_MAX;
                    if (tuple_sum >= refresh_len)
                    begin
                        tuple_sum = 0;
                        if (alt_mode)
                        begin
                            swapped = parity;
                            parity  = !parity;
                        end
                        else
                            swapped = op0_high;
                        built = rebuild(swapped);
                        if (built > ticket_total)
                            ticket_total = built;
                        e.rebuilt = 1'b1;
                    end
                end
                default: ;
            endcase
            e.length = ticket_total[LENGTH_W-1:0];
            items++;
            if (e.granted)
                grants++;
            if (e.rebuilt)
                rebuilds++;
            expected_q = {expected_q, e};
        endfunction

        function void check_result(logic [GRANT_W-1:0] op, logic granted, logic rebuilt,
                                   logic [LENGTH_W-1:0] length);
            grant_result_t e;
            if (expected_q.size() == 0)
            begin
                $error("result beat with no item outstanding");
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (op !== e.op)
            begin
                $error("granted_op: expected %0d, got %0d", e.op, op);
                errors++;
            end
            if (granted !== e.granted)
            begin
                $error("grant_valid: expected %0d, got %0d", e.granted, granted);
                errors++;
            end
            if (rebuilt !== e.rebuilt)
            begin
                $error("refreshed: expected %0d, got %0d", e.rebuilt, rebuilt);
                errors++;
            end
            if (length !== e.length)
            begin
                $error("table_length: expected %0d, got %0d", e.length, length);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    ltsch_cmd_if cmd_ch ();
    ltsch_rsp_if rsp_ch ();
    ltsch_cfg_if cfg_ch ();

    lottery_ticket_scheduler dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    lottery_scoreboard sched;
    int                burst_left;
    int                cur_cycle;
    int                settings;
    longint            cycle_count = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            sched.check_result(rsp_ch.granted_op, rsp_ch.grant_valid, rsp_ch.refreshed,
                               rsp_ch.table_length);
    end

    // result side: quiet, light and heavy stall stretches
    initial
    begin
        int stall;
        int mode;
        int span;
        rsp_ch.ready = 1'b0;
        stall = 0;
        mode  = 0;
        span  = 0;
        forever
        begin
            @(negedge clk);
            if (span == 0)
            begin
                mode = $urandom_range(0, 2);
                span = $urandom_range(50, 400);
            end
            span--;
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if (mode == 1 && $urandom_range(0, 3) == 0)
                    stall = $urandom_range(1, 3);
                else if (mode == 2 && $urandom_range(0, 7) == 0)
                    stall = $urandom_range(5, 30);
            end
        end
    end

    task automatic send_item(input logic [FUNC_W-1:0] f, input logic [RANDOM_BITS_DEF-1:0] rv,
                             input logic [TUPLES_W-1:0] td);
        int gap;
        if (burst_left == 0)
        begin
            cmd_ch.valid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 10);
        end
        burst_left--;
        cmd_ch.valid        <= 1'b1;
        cmd_ch.func         <= f;
        cmd_ch.random_value <= rv;
        cmd_ch.tuples_done  <= td;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        sched.note_item(f, rv, td);
        @(negedge clk);
    endtask

    // hold the sender until every result is back
    task automatic drain();
        cmd_ch.valid <= 1'b0;
        burst_left = 0;
        while (sched.pending() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        sched.write_reg(idx, val);
        @(negedge clk);
    endtask

    task automatic configure(input logic [NUM_OPS_W-1:0] n, input logic [CYCLE_W-1:0] cyc,
                             input logic alt);
        drain();
        write_reg(REG_NUM_OPS, CFG_DATA_W'(n));
        write_reg(REG_REFRESH_LEN, cyc);
        write_reg(REG_ALT_MODE, CFG_DATA_W'(alt));
        cfg_ch.valid <= 1'b0;
        cur_cycle = cyc;
        settings++;
    endtask

    task automatic run_phase(input int quota);
        int                   sent;
        int                   pick;
        int                   hi;
        logic [TUPLES_W-1:0]  td;
        sent = 0;
        send_item(FUNC_START, RANDOM_BITS_DEF'($urandom), TUPLES_W'($urandom));
        while (sent < quota)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 6)
            begin
                send_item(FUNC_START, RANDOM_BITS_DEF'($urandom), TUPLES_W'($urandom));
                sent++;
            end
            else if (pick < 50)
            begin
                send_item(FUNC_DRAW, RANDOM_BITS_DEF'($urandom), TUPLES_W'($urandom));
                sent++;
            end
            else if (pick < 95)
            begin
                case ($urandom_range(0, 9))
                    0:       td = '0;
                    1:       td = TUPLES_W'($urandom);
                    2, 3, 4: td = TUPLES_W'($urandom_range(0, 15));
                    default:
                    begin
                        hi = cur_cycle + cur_cycle / 4;
                        if (hi > 65535)
                            hi = 65535;
                        td = TUPLES_W'($urandom_range(0, hi));
                    end
                endcase
                send_item(FUNC_REPORT, RANDOM_BITS_DEF'($urandom), td);
                sent++;
            end
            else
                send_item(FUNC_UNUSED, RANDOM_BITS_DEF'($urandom), TUPLES_W'($urandom));
        end
    endtask

    initial
    begin
        rst_n               = 1'b0;
        cmd_ch.valid        = 1'b0;
        cmd_ch.func         = FUNC_START;
        cmd_ch.random_value = '0;
        cmd_ch.tuples_done  = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = REG_NUM_OPS;
        cfg_ch.data         = '0;
        sched      = new();
        burst_left = 0;
        cur_cycle  = REFRESH_LEN_RST;
        settings   = 1;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: empty table, report before start, unused code, first rebuild
        send_item(FUNC_DRAW, 15'h7FFF, 16'h0000);
        send_item(FUNC_REPORT, 15'h0000, 16'd10);
        send_item(FUNC_UNUSED, 15'h7FFF, 16'hFFFF);
        send_item(FUNC_REPORT, 15'h0000, 16'd40);
        send_item(FUNC_DRAW, 15'h0000, 16'h0000);
        send_item(FUNC_DRAW, 15'h7FFF, 16'h0000);

        // no requesters, zero cycle length
        configure(5'd0, 16'd0, 1'b1);
        send_item(FUNC_START, 15'h1234, 16'h0000);
        send_item(FUNC_DRAW, 15'h7FFF, 16'h0000);
        send_item(FUNC_REPORT, 15'h0000, 16'h0000);

        // single requester: previous priority of op 0 lowers its share
        configure(5'd1, 16'd1, 1'b1);
        send_item(FUNC_START, 15'h0000, 16'h0000);
        send_item(FUNC_REPORT, 15'h0000, 16'd1);
        send_item(FUNC_REPORT, 15'h0000, 16'd1);
        send_item(FUNC_START, 15'h0000, 16'h0000);
        send_item(FUNC_DRAW, 15'h7FFF, 16'h0000);

        // requester count above the limit, longest cycle
        configure(5'd20, 16'hFFFF, 1'b0);
        send_item(FUNC_START, 15'h0000, 16'h0000);
        send_item(FUNC_DRAW, 15'h7FFF, 16'h0000);
        send_item(FUNC_DRAW, 15'h4000, 16'h0000);
        send_item(FUNC_REPORT, 15'h0000, 16'hFFFF);
        send_item(FUNC_REPORT, 15'h0000, 16'h8000);
        send_item(FUNC_REPORT, 15'h0000, 16'h7FFF);

        // alternate grouping: shorter rebuild keeps the old tail
        configure(5'd20, 16'hFFFF, 1'b1);
        send_item(FUNC_REPORT, 15'h0000, 16'hFFFF);
        send_item(FUNC_REPORT, 15'h0000, 16'hFFFF);
        send_item(FUNC_DRAW, 15'h7FFF, 16'h0000);
        send_item(FUNC_DRAW, 15'h2AAA, 16'h5555);
        send_item(FUNC_UNUSED, 15'h0000, 16'h0000);

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: configure(5'd16, 16'd1, 1'b1);
                1: configure(5'd31, 16'hFFFF, 1'b0);
                2: configure(5'd1, 16'd0, 1'b1);
                default:
                    configure(($urandom_range(0, 9) == 0) ? NUM_OPS_W'($urandom_range(0, 31))
                                                          : NUM_OPS_W'($urandom_range(1, 6)),
                              ($urandom_range(0, 3) == 0) ? CYCLE_W'($urandom)
                                                          : CYCLE_W'($urandom_range(1, 300)),
                              1'($urandom_range(0, 1)));
            endcase
            run_phase(PHASE_ITEMS);
        end

        drain();
        repeat (20) @(posedge clk);
        $display("run covered %0d items over %0d register settings", sched.items, settings);
        $display("grants drawn %0d, table rebuilds %0d", sched.grants, sched.rebuilds);
        if (sched.errors == 0 && sched.pending() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
